// File: rtl/core/rgb_to_yuv420_converter_core_defines.svh
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_core_defines
// assertion macros shared by the converter core
// ----------------------------------------------------------------------------
`ifndef RGB_TO_YUV420_CONVERTER_CORE_DEFINES_SVH
`define RGB_TO_YUV420_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RTV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtv assertion failed");

// next-cycle implication, checked outside reset
`define RTV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtv assertion failed");

`endif

// File: rtl/core/rtv_pkg.sv
// ----------------------------------------------------------------------------
// rtv_pkg
// types and constants of the rgb to yuv 4:2:0 converter core
// ----------------------------------------------------------------------------
package rtv_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_W     = 8;
    localparam int SUM_W     = 9;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd1920;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd1080;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // what the back end does with the pair sums of a pixel
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_STORE  = 2'd1,
        OP_DOUBLE = 2'd2,
        OP_MERGE  = 2'd3
    } t_chroma_op;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic             frame_end;
        t_chroma_op       op;
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
    } t_pix_rec;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic             chroma_valid;
        logic [PIX_W-1:0] cb_value;
        logic [PIX_W-1:0] cr_value;
        logic             frame_end;
    } t_out_rec;

endpackage

// File: rtl/core/rtv_ram.sv
// ----------------------------------------------------------------------------
// rtv_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rtv_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/rtv_fifo.sv
// ----------------------------------------------------------------------------
// rtv_fifo
// small flop-based queue with occupancy count
// ----------------------------------------------------------------------------
module rtv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CNTW  = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty,
    output logic [CNTW-1:0]  o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNTW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// File: rtl/core/rtv_front.sv
// ----------------------------------------------------------------------------
// rtv_front
// frame position tracking, luma and horizontal pair sums per pixel
// ----------------------------------------------------------------------------
module rtv_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int RW         = $clog2(MAX_HEIGHT),
    parameter int AW         = 11
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [rtv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rtv_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_accept,
    input  logic [rtv_pkg::PIX_W-1:0]         i_blue,
    input  logic [rtv_pkg::PIX_W-1:0]         i_green,
    input  logic [rtv_pkg::PIX_W-1:0]         i_red,
    output rtv_pkg::t_pix_rec                 o_rec,
    output logic [AW-1:0]                     o_addr
);

    import rtv_pkg::*;

    localparam int XW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int YW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    logic [CFG_W-1:0]     r_frame_width;
    logic [CFG_W-1:0]     r_frame_height;
    logic [CW-1:0]        r_col, n_col;
    logic [RW-1:0]        r_row, n_row;
    logic [3*PIX_W-1:0]   r_held, n_held;

    logic [XW-1:0]        w_width_ext;
    logic [YW-1:0]        w_height_ext;
    logic [CW-1:0]        w_last_col_idx;
    logic [RW-1:0]        w_last_row_idx;
    logic                 w_last_col, w_last_row, w_have_pair;
    logic [16:0]          w_luma_acc;
    logic [CW-1:0]        w_col_half;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize acts as the maximum
    assign w_width_ext  = XW'(r_frame_width);
    assign w_height_ext = YW'(r_frame_height);

    always_comb begin
        if (w_width_ext == '0) begin
            w_last_col_idx = '0;
        end else if (w_width_ext > XW'(MAX_WIDTH)) begin
            w_last_col_idx = CW'(MAX_WIDTH - 1);
        end else begin
            w_last_col_idx = CW'(w_width_ext - XW'(1));
        end
        if (w_height_ext == '0) begin
            w_last_row_idx = '0;
        end else if (w_height_ext > YW'(MAX_HEIGHT)) begin
            w_last_row_idx = RW'(MAX_HEIGHT - 1);
        end else begin
            w_last_row_idx = RW'(w_height_ext - YW'(1));
        end
    end

    assign w_last_col = (r_col >= w_last_col_idx);
    assign w_last_row = (r_row >= w_last_row_idx);
    assign w_col_half = r_col >> 1;
    assign o_addr     = AW'(w_col_half);

    assign w_luma_acc = 17'(i_red) * 17'd66 + 17'(i_green) * 17'd129
                      + 17'(i_blue) * 17'd25 + 17'd128;

    always_comb begin
        o_rec.luma      = 8'(w_luma_acc >> 8) + 8'd16;
        o_rec.frame_end = w_last_col & w_last_row;
        o_rec.sum_r     = '0;
        o_rec.sum_g     = '0;
        o_rec.sum_b     = '0;
        w_have_pair     = 1'b0;
        n_held          = r_held;
        if (!r_col[0] && !w_last_col) begin
            n_held = {i_red, i_green, i_blue};
        end else if (!r_col[0]) begin
            // odd last column: the pixel stands in for its right neighbour
            o_rec.sum_r = {i_red, 1'b0};
            o_rec.sum_g = {i_green, 1'b0};
            o_rec.sum_b = {i_blue, 1'b0};
            w_have_pair = 1'b1;
        end else begin
            o_rec.sum_r = SUM_W'(r_held[3*PIX_W-1:2*PIX_W]) + SUM_W'(i_red);
            o_rec.sum_g = SUM_W'(r_held[2*PIX_W-1:PIX_W]) + SUM_W'(i_green);
            o_rec.sum_b = SUM_W'(r_held[PIX_W-1:0]) + SUM_W'(i_blue);
            w_have_pair = 1'b1;
        end
        if (!w_have_pair) begin
            o_rec.op = OP_NONE;
        end else if (!r_row[0] && !w_last_row) begin
            o_rec.op = OP_STORE;
        end else if (!r_row[0]) begin
            o_rec.op = OP_DOUBLE;
        end else begin
            o_rec.op = OP_MERGE;
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_last_col) begin
            n_col = '0;
            n_row = w_last_row ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (i_accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_held <= n_held;
        end
    end

endmodule

// File: rtl/core/rtv_back.sv
// ----------------------------------------------------------------------------
// rtv_back
// line store access, 2x2 block averaging and chroma arithmetic
// ----------------------------------------------------------------------------
module rtv_back #(
    parameter int LINE_DEPTH = 2048,
    parameter int AW         = 11,
    parameter int OUT_DEPTH  = 4,
    parameter int OCW        = $clog2(OUT_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rtv_pkg::t_pix_rec i_head,
    input  logic [AW-1:0]     i_head_addr,
    input  logic              i_mid_empty,
    output logic              o_mid_pop,
    input  logic [OCW-1:0]    i_out_count,
    output logic              o_out_push,
    output rtv_pkg::t_out_rec o_out_rec
);

    import rtv_pkg::*;

    localparam int LW = 3 * SUM_W;

    logic                r_s1_valid;
    t_pix_rec            r_s1_rec;
    logic                r_s2_valid;
    logic [PIX_W-1:0]    r_s2_luma;
    logic                r_s2_chroma;
    logic                r_s2_frame_end;
    logic [PIX_W-1:0]    r_s2_avg_r, r_s2_avg_g, r_s2_avg_b;

    logic [OCW:0]        w_busy;
    logic [LW-1:0]       w_line_rd;
    logic [SUM_W:0]      w_sr, w_sg, w_sb;
    logic signed [16:0]  w_ar, w_ag, w_ab;
    logic signed [16:0]  w_cb_acc, w_cr_acc;
    logic signed [16:0]  w_cb_off, w_cr_off;

    function automatic logic [PIX_W-1:0] clamp_u8(input logic signed [16:0] v);
        logic [PIX_W-1:0] res;
        if (v < 17'sd0) begin
            res = '0;
        end else if (v > 17'sd255) begin
            res = 8'd255;
        end else begin
            res = PIX_W'(v);
        end
        return res;
    endfunction

    // items in flight are counted against the output queue space
    assign w_busy    = (OCW + 1)'(i_out_count) + (OCW + 1)'(r_s1_valid)
                     + (OCW + 1)'(r_s2_valid);
    assign o_mid_pop = ~i_mid_empty & (w_busy < (OCW + 1)'(OUT_DEPTH));

    rtv_ram #(
        .WIDTH (LW),
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (o_mid_pop && (i_head.op == OP_STORE)),
        .i_wr_addr (i_head_addr),
        .i_wr_data ({i_head.sum_r, i_head.sum_g, i_head.sum_b}),
        .i_rd_en   (o_mid_pop && (i_head.op == OP_MERGE)),
        .i_rd_addr (i_head_addr),
        .o_rd_data (w_line_rd)
    );

    // vertical combine of the pair sums
    always_comb begin
        case (r_s1_rec.op)
            OP_DOUBLE: begin
                w_sr = {r_s1_rec.sum_r, 1'b0};
                w_sg = {r_s1_rec.sum_g, 1'b0};
                w_sb = {r_s1_rec.sum_b, 1'b0};
            end
            OP_MERGE: begin
                w_sr = (SUM_W + 1)'(w_line_rd[LW-1:2*SUM_W]) + (SUM_W + 1)'(r_s1_rec.sum_r);
                w_sg = (SUM_W + 1)'(w_line_rd[2*SUM_W-1:SUM_W]) + (SUM_W + 1)'(r_s1_rec.sum_g);
                w_sb = (SUM_W + 1)'(w_line_rd[SUM_W-1:0]) + (SUM_W + 1)'(r_s1_rec.sum_b);
            end
            default: begin
                w_sr = '0;
                w_sg = '0;
                w_sb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_mid_pop;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_rec       <= i_head;
        r_s2_luma      <= r_s1_rec.luma;
        r_s2_frame_end <= r_s1_rec.frame_end;
        r_s2_chroma    <= (r_s1_rec.op == OP_DOUBLE) || (r_s1_rec.op == OP_MERGE);
        r_s2_avg_r     <= PIX_W'(w_sr >> 2);
        r_s2_avg_g     <= PIX_W'(w_sg >> 2);
        r_s2_avg_b     <= PIX_W'(w_sb >> 2);
    end

    assign w_ar = $signed(17'(r_s2_avg_r));
    assign w_ag = $signed(17'(r_s2_avg_g));
    assign w_ab = $signed(17'(r_s2_avg_b));

    assign w_cb_acc = w_ab * 17'sd112 - w_ar * 17'sd38 - w_ag * 17'sd74 + 17'sd128;
    assign w_cr_acc = w_ar * 17'sd112 - w_ag * 17'sd94 - w_ab * 17'sd18 + 17'sd128;
    // arithmetic shift gives the floor
    assign w_cb_off = (w_cb_acc >>> 8) + 17'sd128;
    assign w_cr_off = (w_cr_acc >>> 8) + 17'sd128;

    assign o_out_push = r_s2_valid;

    always_comb begin
        o_out_rec.luma         = r_s2_luma;
        o_out_rec.chroma_valid = r_s2_chroma;
        o_out_rec.frame_end    = r_s2_frame_end;
        o_out_rec.cb_value     = r_s2_chroma ? clamp_u8(w_cb_off) : '0;
        o_out_rec.cr_value     = r_s2_chroma ? clamp_u8(w_cr_off) : '0;
    end

endmodule

// File: rtl/core/rgb_to_yuv420_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_core
// bt.601 rgb to yuv 4:2:0 conversion, luma per pixel, chroma per 2x2 block
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------------------
//  pixel in | in        | push / full                | i_blue, i_green, i_red
//  result   | out       | empty / pop                | o_luma, o_chroma_valid,
//           |           |                            | o_cb_value, o_cr_value, o_frame_end
//  config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  one pixel a cycle sustained while the result side keeps popping; a taken beat passes
//  the mid queue, the line store read and block average stages, then the result queue
//  the line store is one simple dual-port ram, one write and one read per cycle
//  reset is synchronous and active low; no clearing pass, the line store is
//  always written on an even row before the odd row reads it
//  a full result queue stalls the back end, the mid queue then fills and raises full
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [rtv_pkg::PIX_W-1:0]     i_blue,
    input  logic [rtv_pkg::PIX_W-1:0]     i_green,
    input  logic [rtv_pkg::PIX_W-1:0]     i_red,
    output logic                          empty,
    input  logic                          pop,
    output logic [rtv_pkg::PIX_W-1:0]     o_luma,
    output logic                          o_chroma_valid,
    output logic [rtv_pkg::PIX_W-1:0]     o_cb_value,
    output logic [rtv_pkg::PIX_W-1:0]     o_cr_value,
    output logic                          o_frame_end,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rtv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rtv_pkg::CFG_W-1:0]     i_cfg_data
);

    import rtv_pkg::*;

`include "rgb_to_yuv420_converter_core_defines.svh"

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int RW         = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int MID_DEPTH  = 4;
    localparam int OUT_DEPTH  = 4;
    localparam int MCW        = $clog2(MID_DEPTH + 1);
    localparam int OCW        = $clog2(OUT_DEPTH + 1);
    localparam int REC_W      = $bits(t_pix_rec);
    localparam int OREC_W     = $bits(t_out_rec);

    logic              w_in_accept;
    t_pix_rec          w_front_rec;
    logic [AW-1:0]     w_front_addr;
    logic [AW+REC_W-1:0] w_mid_rd;
    t_pix_rec          w_head;
    logic [AW-1:0]     w_head_addr;
    logic              w_mid_empty, w_mid_pop;
    logic [MCW-1:0]    w_mid_count;
    logic              w_out_push, w_out_full;
    t_out_rec          w_out_rec, w_res;
    logic [OREC_W-1:0] w_out_rd;
    logic [OCW-1:0]    w_out_count;

    assign o_cfg_ready = 1'b1;
    assign w_in_accept = push & ~full;

    rtv_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW),
        .AW         (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_in_accept),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .o_rec       (w_front_rec),
        .o_addr      (w_front_addr)
    );

    rtv_fifo #(
        .WIDTH (AW + REC_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_in_accept),
        .i_wr_data ({w_front_addr, w_front_rec}),
        .i_pop     (w_mid_pop),
        .o_rd_data (w_mid_rd),
        .o_full    (full),
        .o_empty   (w_mid_empty),
        .o_count   (w_mid_count)
    );

    assign w_head      = t_pix_rec'(w_mid_rd[REC_W-1:0]);
    assign w_head_addr = w_mid_rd[AW+REC_W-1:REC_W];

    rtv_back #(
        .LINE_DEPTH (LINE_DEPTH),
        .AW         (AW),
        .OUT_DEPTH  (OUT_DEPTH),
        .OCW        (OCW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_head_addr (w_head_addr),
        .i_mid_empty (w_mid_empty),
        .o_mid_pop   (w_mid_pop),
        .i_out_count (w_out_count),
        .o_out_push  (w_out_push),
        .o_out_rec   (w_out_rec)
    );

    rtv_fifo #(
        .WIDTH (OREC_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_out_push),
        .i_wr_data (w_out_rec),
        .i_pop     (pop),
        .o_rd_data (w_out_rd),
        .o_full    (w_out_full),
        .o_empty   (empty),
        .o_count   (w_out_count)
    );

    assign w_res          = t_out_rec'(w_out_rd);
    assign o_luma         = w_res.luma;
    assign o_chroma_valid = w_res.chroma_valid;
    assign o_cb_value     = w_res.cb_value;
    assign o_cr_value     = w_res.cr_value;
    assign o_frame_end    = w_res.frame_end;

    // the back end only pops what the result queue can still take
    `RTV_ASSERT_IMPL(a_out_no_overflow, i_clk, i_rst_n, w_out_push, !w_out_full)
    // the last pixel of a frame always closes a block
    `RTV_ASSERT_IMPL(a_frame_end_chroma, i_clk, i_rst_n, (!empty && o_frame_end), o_chroma_valid)
    `RTV_ASSERT_IMPL(a_no_chroma_zero, i_clk, i_rst_n, (!empty && !o_chroma_valid), ((o_cb_value == 8'd0) && (o_cr_value == 8'd0)))
    // a mid queue pop never happens with the queue empty, so a pop without a push lowers its count by one
    `RTV_ASSERT_NEXT(a_mid_count_step, i_clk, i_rst_n, (w_mid_pop && !w_in_accept), (w_mid_count == $past(w_mid_count) - 3'd1))

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the rgb to yuv 4:2:0 converter core: pixels go in
// through the push/full queue port, every output beat is compared field by
// field against a bt.601 predictor kept in the scoreboard below. directed
// frames cover colour extremes, odd edges, zero and oversized dimensions and
// size changes inside a frame; random frames follow with bursty input and a
// stalling output side.
// ----------------------------------------------------------------------------

class yuv_sample_checker;

    typedef struct packed {
        logic [8:0] r;
        logic [8:0] g;
        logic [8:0] b;
    } t_pair_sum;

    int unsigned max_w;
    int unsigned max_h;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    int unsigned col_pos;
    int unsigned row_pos;
    logic [23:0] held_pix;
    t_pair_sum   line_sums[];
    rtv_pkg::t_out_rec expected_samples[$];
    int unsigned mismatches;

    function new(int unsigned mw, int unsigned mh);
        max_w      = mw;
        max_h      = mh;
        width_reg  = rtv_pkg::WIDTH_RESET;
        height_reg = rtv_pkg::HEIGHT_RESET;
        col_pos    = 0;
        row_pos    = 0;
        held_pix   = '0;
        mismatches = 0;
        line_sums  = new[(mw + 1) / 2];
        foreach (line_sums[i]) line_sums[i] = '0;
    endfunction

    static function int unsigned eff_dim(logic [12:0] v, int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    static function logic [7:0] sat_u8(int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    function void set_reg(rtv_pkg::t_cfg_reg idx, logic [12:0] value);
        case (idx)
            rtv_pkg::REG_FRAME_WIDTH:  width_reg  = value;
            rtv_pkg::REG_FRAME_HEIGHT: height_reg = value;
            default: ;
        endcase
    endfunction

    function int unsigned frame_pixels();
        return eff_dim(width_reg, max_w) * eff_dim(height_reg, max_h);
    endfunction

    function int unsigned pending();
        return expected_samples.size();
    endfunction

    function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        int unsigned w;
        int unsigned h;
        int unsigned idx;
        bit last_col;
        bit last_row;
        bit have_pair;
        int ri, gi, bi;
        int pr, pg, pb;
        int sr, sg, sb;
        int ar, ag, ab;
        rtv_pkg::t_out_rec res;

        w        = eff_dim(width_reg, max_w);
        h        = eff_dim(height_reg, max_h);
        last_col = col_pos >= w - 1;
        last_row = row_pos >= h - 1;
        idx      = (col_pos >> 1) % line_sums.size();
        ri       = r;
        gi       = g;
        bi       = b;
        res      = '0;
        pr       = 0;
        pg       = 0;
        pb       = 0;
        have_pair = 1'b1;

        res.luma = sat_u8(((66 * ri + 129 * gi + 25 * bi + 128) >> 8) + 16);

        if (col_pos % 2 == 0 && !last_col) begin
            held_pix  = {r, g, b};
            have_pair = 1'b0;
        end else if (col_pos % 2 == 0) begin
            // odd last column: pixel pairs with itself
            pr = 2 * ri;
            pg = 2 * gi;
            pb = 2 * bi;
        end else begin
            pr = int'(held_pix[23:16]) + ri;
            pg = int'(held_pix[15:8]) + gi;
            pb = int'(held_pix[7:0]) + bi;
        end

        if (have_pair) begin
            if (row_pos % 2 == 0 && !last_row) begin
                line_sums[idx] = {9'(pr), 9'(pg), 9'(pb)};
            end else begin
                if (row_pos % 2 == 0) begin
                    // odd last row: no partner row, even row counts twice
                    sr = 2 * pr;
                    sg = 2 * pg;
                    sb = 2 * pb;
                end else begin
                    sr = int'(line_sums[idx].r) + pr;
                    sg = int'(line_sums[idx].g) + pg;
                    sb = int'(line_sums[idx].b) + pb;
                end
                ar = sr >> 2;
                ag = sg >> 2;
                ab = sb >> 2;
                res.chroma_valid = 1'b1;
                res.cb_value = sat_u8(((-38 * ar - 74 * ag + 112 * ab + 128) >>> 8) + 128);
                res.cr_value = sat_u8(((112 * ar - 94 * ag - 18 * ab + 128) >>> 8) + 128);
            end
        end

        res.frame_end = last_col && last_row;
        expected_samples.push_back(res);

        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function void check_sample(rtv_pkg::t_out_rec got);
        rtv_pkg::t_out_rec want;
        if (expected_samples.size() == 0) begin
            $error("output beat with no pixel outstanding: luma %0d", got.luma);
            mismatches++;
            return;
        end
        want = expected_samples.pop_front();
        compare_field("luma", want.luma, got.luma);
        compare_field("chroma_valid", 8'(want.chroma_valid), 8'(got.chroma_valid));
        compare_field("cb_value", want.cb_value, got.cb_value);
        compare_field("cr_value", want.cr_value, got.cr_value);
        compare_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
    endfunction

endclass

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import rtv_pkg::*;

    localparam int MAX_W = 4096;
    localparam int MAX_H = 4096;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               push           = 1'b0;
    logic               full;
    logic [PIX_W-1:0]   i_blue         = '0;
    logic [PIX_W-1:0]   i_green        = '0;
    logic [PIX_W-1:0]   i_red          = '0;
    logic               empty;
    logic               pop            = 1'b0;
    logic [PIX_W-1:0]   o_luma;
    logic               o_chroma_valid;
    logic [PIX_W-1:0]   o_cb_value;
    logic [PIX_W-1:0]   o_cr_value;
    logic               o_frame_end;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [CFG_W-1:0]   i_cfg_data     = '0;

    yuv_sample_checker sb = new(MAX_W, MAX_H);

    int unsigned pixels_sent = 0;
    int unsigned burst_left  = 0;
    bit          hold_off_req = 1'b0;

    rgb_to_yuv420_converter_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_blue         (i_blue),
        .i_green        (i_green),
        .i_red          (i_red),
        .empty          (empty),
        .pop            (pop),
        .o_luma         (o_luma),
        .o_chroma_valid (o_chroma_valid),
        .o_cb_value     (o_cb_value),
        .o_cr_value     (o_cr_value),
        .o_frame_end    (o_frame_end),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic idle_cycles(int unsigned n);
        push <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // only while nothing is in flight, so the block is idle
    task automatic write_reg(t_cfg_reg idx, logic [CFG_W-1:0] value);
        bit taken;
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic offer_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        bit taken;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        push    <= 1'b1;
        i_blue  <= b;
        i_green <= g;
        i_red   <= r;
        do begin
            @(negedge i_clk);
            taken = !full;
            @(posedge i_clk);
        end while (!taken);
        sb.note_pixel(b, g, r);
        pixels_sent++;
    endtask

    function automatic logic [7:0] rand_component();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic offer_random_pixel();
        offer_pixel(rand_component(), rand_component(), rand_component());
    endtask

    task automatic send_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        int unsigned n;
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        n = sb.frame_pixels();
        repeat (n) offer_random_pixel();
    endtask

    // output side: changing stall pattern plus one long hold-off on request
    initial begin : result_sink
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        rtv_pkg::t_out_rec got;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = 300;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    default: pop <= ($urandom_range(0, 4) == 0);
                endcase
            end
            @(negedge i_clk);
            if (pop && !empty) begin
                got.luma         = o_luma;
                got.chroma_valid = o_chroma_valid;
                got.cb_value     = o_cb_value;
                got.cr_value     = o_cr_value;
                got.frame_end    = o_frame_end;
                sb.check_sample(got);
            end
        end
    end

    initial begin : stimulus
        int unsigned drain_wait;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x3 frame: odd last column and odd last row, colour extremes
        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        offer_pixel(8'd0,   8'd0,   8'd0);
        offer_pixel(8'd255, 8'd255, 8'd255);
        offer_pixel(8'd255, 8'd0,   8'd0);
        offer_pixel(8'd0,   8'd255, 8'd0);
        offer_pixel(8'd0,   8'd0,   8'd255);
        offer_pixel(8'd255, 8'd255, 8'd0);
        offer_pixel(8'd0,   8'd255, 8'd255);
        offer_pixel(8'd255, 8'd0,   8'd255);
        offer_pixel(8'd128, 8'd128, 8'd128);

        // zero dimensions behave as 1x1
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, 13'd0);
        offer_pixel(8'd255, 8'd0, 8'd255);
        offer_pixel(8'd0, 8'd255, 8'd0);

        // height cut short at an even row boundary, that row becomes the last
        write_reg(REG_FRAME_WIDTH, 13'd2);
        write_reg(REG_FRAME_HEIGHT, 13'd6);
        repeat (4) offer_random_pixel();
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        repeat (2) offer_random_pixel();

        // width cut mid row on an even row, column beyond the end closes it
        write_reg(REG_FRAME_WIDTH, 13'd6);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        repeat (4) offer_random_pixel();
        write_reg(REG_FRAME_WIDTH, 13'd3);
        repeat (4) offer_random_pixel();

        // random small frames
        while (pixels_sent < 430) begin
            w = ($urandom_range(0, 15) == 0) ? 13'd0 : 13'($urandom_range(1, 12));
            h = ($urandom_range(0, 15) == 0) ? 13'd0 : 13'($urandom_range(1, 8));
            send_frame(w, h);
        end

        // oversized registers clip to the maximum; a short width then ends the row
        write_reg(REG_FRAME_WIDTH, 13'h1FFF);
        write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
        // output side holds off while the input keeps offering, so the block fills
        hold_off_req = 1'b1;
        repeat (40) offer_random_pixel();
        write_reg(REG_FRAME_WIDTH, 13'd4);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        repeat (4) offer_random_pixel();

        push <= 1'b0;
        drain_wait = 0;
        while (sb.pending() != 0 && drain_wait < 20000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d output beats never arrived", sb.pending());
            sb.mismatches++;
        end

        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rtv_pkg.sv
rtl/core/rtv_ram.sv
rtl/core/rtv_fifo.sv
rtl/core/rtv_front.sv
rtl/core/rtv_back.sv
rtl/core/rgb_to_yuv420_converter_core.sv
tb/sv/testbench.sv
